/* rtl/core/rv32s_pkg.sv */
// Package for the rv32 subset executor: sizes, opcodes, ALU codes, result struct.
// No dependencies; used by every file in rtl/core.
package rv32s_pkg;

	localparam int MEM_WORDS  = 32;
	localparam int PROG_DEPTH = 1024;
	localparam int MA_W       = $clog2(MEM_WORDS);
	localparam int PI_W       = $clog2(PROG_DEPTH);
	localparam int PL_W       = 11;

	localparam logic [6:0] OP_R     = 7'b0110011;
	localparam logic [6:0] OP_I     = 7'b0010011;
	localparam logic [6:0] OP_LOAD  = 7'b0000011;
	localparam logic [6:0] OP_STORE = 7'b0100011;
	localparam logic [6:0] OP_BR    = 7'b1100011;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_MUL = 3'd2;
	localparam logic [2:0] F3_DIV = 3'd3;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_SR  = 3'd5;
	localparam logic [2:0] F3_OR  = 3'd6;

	localparam logic [2:0] BR_EQ = 3'd0;
	localparam logic [2:0] BR_NE = 3'd1;
	localparam logic [2:0] BR_LT = 3'd4;
	localparam logic [2:0] BR_GE = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BADOP = 2'd1;
	localparam logic [1:0] ST_BADBR = 2'd2;
	localparam logic [1:0] ST_BADAD = 2'd3;

	// handshake between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] q;
	} div_rsp_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] mem_value;
		logic [4:0]  mem_addr;
		logic        mem_write;
		logic [31:0] reg_value;
		logic [4:0]  reg_dest;
		logic        reg_write;
		logic        taken;
		logic        program_end;
		logic [9:0]  next_index;
	} result_t;

	function automatic logic [31:0] sext12(input logic [11:0] r);
		return {{20{r[11]}}, r};
	endfunction

endpackage

/* rtl/core/rv32_subset_instruction_executor.sv */
// Top level of the rv32 subset executor: sequencer, register file, data memory.
// Depends on rv32s_pkg and rv32s_div.
//
// channel   dir  fields (lsb first)
// s_axis    in   tdata: instruction[31:0]
// m_axis    out  tdata: next_index, program_end, taken, reg_write, reg_dest,
//                       reg_value, mem_write, mem_addr, mem_value, status
// cfg       in   program_length[10:0]
//
// A word runs from acceptance to the next ready through accept and read rs1,
// read rs2, execute and write back, output; loads with a valid address and MUL
// also pass through S_LD or S_MUL (registered memory read, registered 32x32
// product); DIV waits in S_DIV while the divider makes one quotient bit per
// cycle and flags done after the last bit. The register file and data memory
// have a registered read; operands are read one per cycle. Reset clears both
// by a sweep over every word; s_axis_tready stays low meanwhile. A waiting
// result holds until m_axis_tready; the next word may run and wait in S_OUT.
module rv32_subset_instruction_executor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,       // program_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,    // instruction
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata     // see table above, zero filled
);
	typedef enum logic [8:0] {
		S_CLR  = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_RDA  = 9'b000000100,
		S_RDB  = 9'b000001000,
		S_EXE  = 9'b000010000,
		S_MUL  = 9'b000100000,
		S_DIV  = 9'b001000000,
		S_LD   = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [31:0] ins_q, a_q, b_q, mul_q;
	logic [rv32s_pkg::PL_W-1:0] plen_q;
	logic [rv32s_pkg::PI_W-1:0] pc_q;
	logic [4:0]  clr_q;
	rv32s_pkg::result_t res_q;
	logic        out_v_q;

	logic [31:0] rf [32];
	logic [31:0] dm [rv32s_pkg::MEM_WORDS];
	logic [31:0] rf_rd, dm_rd;
	logic [4:0]  rf_ra;
	logic        rf_we, dm_we;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;
	logic [rv32s_pkg::MA_W-1:0] dm_a;

	rv32s_pkg::div_req_t dreq;
	rv32s_pkg::div_rsp_t drsp;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic        alt;
	logic [31:0] opb, imm, addr, alu, diff;
	logic        brt, brbad;
	logic [12:0] boff;
	logic signed [12:0] tgt;
	logic [10:0] limit;

	assign opc = ins_q[6:0];
	assign f3  = ins_q[14:12];
	assign rd  = ins_q[11:7];
	assign alt = ins_q[30] && (f3 == rv32s_pkg::F3_SR ||
		(opc == rv32s_pkg::OP_R && f3 == rv32s_pkg::F3_ADD));
	assign opb = (opc == rv32s_pkg::OP_R) ? b_q : rv32s_pkg::sext12(ins_q[31:20]);
	assign imm = (opc == rv32s_pkg::OP_LOAD) ? rv32s_pkg::sext12(ins_q[31:20])
		: rv32s_pkg::sext12({ins_q[31:25], ins_q[11:7]});
	assign addr = a_q + imm;
	assign diff = a_q - b_q;

	always_comb begin
		case (f3)
			rv32s_pkg::F3_ADD: alu = alt ? a_q - opb : a_q + opb;
			rv32s_pkg::F3_SLL: alu = a_q << opb[4:0];
			rv32s_pkg::F3_XOR: alu = a_q ^ opb;
			rv32s_pkg::F3_SR:  alu = alt ? 32'($signed(a_q) >>> opb[4:0]) : a_q >> opb[4:0];
			rv32s_pkg::F3_OR:  alu = a_q | opb;
			default:           alu = a_q & opb;
		endcase
	end

	always_comb begin
		brbad = 1'b0;
		case (f3)
			rv32s_pkg::BR_EQ: brt = (diff == 32'd0);
			rv32s_pkg::BR_NE: brt = (diff != 32'd0);
			rv32s_pkg::BR_LT: brt = diff[31];
			rv32s_pkg::BR_GE: brt = !diff[31];
			default: begin
				brt   = 1'b0;
				brbad = 1'b1;
			end
		endcase
	end

	assign boff  = {ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
	assign limit = (plen_q > 11'(rv32s_pkg::PROG_DEPTH)) ? 11'(rv32s_pkg::PROG_DEPTH) : plen_q;

	// branch target uses boff[12:1], the halved offset
	always_comb begin
		if (opc == rv32s_pkg::OP_BR && brt)
			tgt = $signed({3'b000, pc_q}) + $signed({boff[12], boff[12:1]});
		else
			tgt = $signed({3'b000, pc_q}) + 13'sd1;
	end

	assign dreq.a     = a_q;
	assign dreq.b     = opb;
	assign dreq.start = (state_q == S_EXE) && f3 == rv32s_pkg::F3_DIV &&
		(opc == rv32s_pkg::OP_R || opc == rv32s_pkg::OP_I);

	rv32s_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign rf_ra = (state_q == S_IDLE) ? s_axis_tdata[19:15] : ins_q[24:20];
	assign dm_a  = addr[rv32s_pkg::MA_W-1:0];

	always_ff @(posedge clk) begin
		if (rf_we)
			rf[rf_wa] <= rf_wd;
		rf_rd <= rf[rf_ra];
		if (dm_we)
			dm[(state_q == S_CLR) ? clr_q : dm_a] <= (state_q == S_CLR) ? 32'd0 : b_q;
		dm_rd <= dm[dm_a];
		mul_q <= a_q * opb;
	end

	// write and result assembly
	logic        wr_en;
	logic [31:0] wr_val;
	logic [1:0]  st;
	logic        is_alu, is_mem, bad_ad;

	assign is_alu = (opc == rv32s_pkg::OP_R || opc == rv32s_pkg::OP_I);
	assign is_mem = (opc == rv32s_pkg::OP_LOAD || opc == rv32s_pkg::OP_STORE);
	assign bad_ad = addr >= 32'(rv32s_pkg::MEM_WORDS);

	always_comb begin
		st = rv32s_pkg::ST_OK;
		if (is_mem && bad_ad)
			st = rv32s_pkg::ST_BADAD;
		else if (opc == rv32s_pkg::OP_BR && brbad)
			st = rv32s_pkg::ST_BADBR;
		else if (!is_alu && !is_mem && opc != rv32s_pkg::OP_BR)
			st = rv32s_pkg::ST_BADOP;
	end

	always_comb begin
		case (state_q)
			S_MUL:   wr_val = mul_q;
			S_DIV:   wr_val = drsp.q;
			S_LD:    wr_val = dm_rd;
			default: wr_val = alu;
		endcase
	end

	assign wr_en = (rd != 5'd0) && (
		(state_q == S_EXE && is_alu && f3 != rv32s_pkg::F3_MUL && f3 != rv32s_pkg::F3_DIV) ||
		state_q == S_MUL || (state_q == S_DIV && drsp.done) || state_q == S_LD);

	assign rf_we = (state_q == S_CLR) || wr_en;
	assign rf_wa = (state_q == S_CLR) ? clr_q : rd;
	assign rf_wd = (state_q == S_CLR) ? 32'd0 : wr_val;
	assign dm_we = (state_q == S_CLR) ||
		(state_q == S_EXE && opc == rv32s_pkg::OP_STORE && !bad_ad);

	logic fin;
	assign fin = (state_q == S_EXE && !(is_alu && (f3 == rv32s_pkg::F3_MUL ||
		f3 == rv32s_pkg::F3_DIV)) && !(opc == rv32s_pkg::OP_LOAD && !bad_ad)) ||
		state_q == S_MUL || (state_q == S_DIV && drsp.done) || state_q == S_LD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			plen_q  <= '0;
			pc_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we)
				plen_q <= cfg_wdata;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 5'd1;
					if (clr_q == 5'd31)
						state_q <= S_IDLE;
				end
				S_IDLE: if (s_axis_tvalid) state_q <= S_RDA;
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_EXE;
				S_EXE: begin
					if (is_alu && f3 == rv32s_pkg::F3_MUL)
						state_q <= S_MUL;
					else if (is_alu && f3 == rv32s_pkg::F3_DIV)
						state_q <= S_DIV;
					else if (opc == rv32s_pkg::OP_LOAD && !bad_ad)
						state_q <= S_LD;
					else
						state_q <= S_OUT;
				end
				S_MUL: state_q <= S_OUT;
				S_LD:  state_q <= S_OUT;
				S_DIV: if (drsp.done) state_q <= S_OUT;
				S_OUT: if (!out_v_q || m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (fin)
				pc_q <= tgt[rv32s_pkg::PI_W-1:0];
			if (state_q == S_OUT && (!out_v_q || m_axis_tready))
				out_v_q <= 1'b1;
			else if (m_axis_tready)
				out_v_q <= 1'b0;
		end
	end

	rv32s_pkg::result_t nres_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE)
			ins_q <= s_axis_tdata;
		// rs1 read lands in RDA, rs2 read lands in RDB
		if (state_q == S_RDA)
			a_q <= rf_rd;
		if (state_q == S_RDB)
			b_q <= rf_rd;
		if (fin) begin
			nres_q.next_index  <= tgt[rv32s_pkg::PI_W-1:0];
			nres_q.program_end <= tgt[12] || (tgt[11:0] >= {1'b0, limit});
			nres_q.taken       <= (opc == rv32s_pkg::OP_BR) && brt;
			nres_q.reg_write   <= wr_en;
			nres_q.reg_dest    <= wr_en ? rd : 5'd0;
			nres_q.reg_value   <= wr_en ? wr_val : 32'd0;
			nres_q.mem_write   <= opc == rv32s_pkg::OP_STORE && !bad_ad;
			nres_q.mem_addr    <= (is_mem && !bad_ad) ? 5'(addr) : 5'd0;
			nres_q.mem_value   <= (opc == rv32s_pkg::OP_STORE && !bad_ad) ? b_q : 32'd0;
			nres_q.status      <= st;
		end
		if (state_q == S_OUT && (!out_v_q || m_axis_tready))
			res_q <= nres_q;
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {6'd0, res_q.status, res_q.mem_value, res_q.mem_addr,
		res_q.mem_write, res_q.reg_value, res_q.reg_dest, res_q.reg_write,
		res_q.taken, res_q.program_end, res_q.next_index};
endmodule

/* rtl/core/rv32s_div.sv */
// Signed 32-bit divider, one quotient bit per cycle (restoring).
// Depends on rv32s_pkg.
module rv32s_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rv32s_pkg::div_req_t req,
	output rv32s_pkg::div_rsp_t rsp
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q, zero_q, done_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial   = {1'b0, shifted} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quo_q  <= req.a[31] ? 32'd0 - req.a : req.a;
			den_q  <= req.b[31] ? 32'd0 - req.b : req.b;
			neg_q  <= req.a[31] ^ req.b[31];
			zero_q <= (req.b == 32'd0);
		end else if (busy_q) begin
			// shift one dividend bit in, subtract when it fits
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (zero_q)
			rsp.q = 32'hFFFF_FFFF;
		else
			rsp.q = neg_q ? 32'd0 - quo_q : quo_q;
	end
endmodule

/* rtl/core/rv32s_checker.sv */
// Port-level checks for the rv32 subset executor, bound to the top level.
// Depends on rv32s_pkg and the top level's ports.
module rv32s_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted a word while busy");

	a_x0_never: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[12] || m_axis_tdata[17:13] == 5'd0))
		else $error("destination without write");

	a_store_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[50] |-> m_axis_tdata[89:88] == rv32s_pkg::ST_OK)
		else $error("store flagged with error");
endmodule

bind rv32_subset_instruction_executor rv32s_checker u_rv32s_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
